@@ design/psls_pkg.sv @@
// package for the per-source latency statistics block
// holds item and table entry types, action codes, sequencer states and divider status; no dependencies
`default_nettype none

package psls_pkg;

    localparam int NUM_SOURCES_DEF = 16;
    localparam int ACTION_W        = 2;
    localparam int SRC_W           = 4;
    localparam int DATA_W          = 32;
    localparam int TOTAL_W         = 64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PRODUCED = 2'd0,
        ACT_CONSUMED = 2'd1,
        ACT_READ     = 2'd2,
        ACT_SPARE    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SRC_W-1:0]    source;
        logic [DATA_W-1:0]   delay_us;
    } req_item_t;

    typedef struct packed {
        logic [SRC_W-1:0]  source_echo;
        logic [DATA_W-1:0] made_count;
        logic [DATA_W-1:0] eaten_count;
        logic              has_samples;
        logic [DATA_W-1:0] shortest_delay;
        logic [DATA_W-1:0] longest_delay;
        logic [DATA_W-1:0] mean_delay;
        logic              count_mismatch;
    } rsp_item_t;

    // one row of the statistics table
    typedef struct packed {
        logic [DATA_W-1:0]  made;
        logic [DATA_W-1:0]  eaten;
        logic               has;
        logic [DATA_W-1:0]  min;
        logic [DATA_W-1:0]  max;
        logic [TOTAL_W-1:0] total;
    } entry_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

`default_nettype wire

@@ design/psls_if.sv @@
// request and result channels of the per-source latency statistics block
// depends on psls_pkg for the payload types
`default_nettype none

interface psls_req_if;
    logic                  valid;
    logic                  ready;
    psls_pkg::req_item_t   item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface psls_rsp_if;
    logic                  valid;
    logic                  ready;
    psls_pkg::rsp_item_t   item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

@@ design/per_source_latency_statistics_core.sv @@
// per-source latency statistics: counts, min, max and mean delay for each source
//
// channels: req (sink) carries action, source and delay_us; rsp (source) returns one
// result per request with the entry as it stands after the request was applied.
// a request is taken when req.valid and req.ready are both high. the block takes one
// request at a time: req.ready is high only while the sequencer is idle.
// sequence: a request that leaves its row without samples, or one with an out-of-range
// source, goes from the update step straight to the finish step; a request that needs
// a mean passes through the divide step, which skips the bitwise division when the
// quotient saturates at 32 bits. the mean comes from one shared restoring divider
// retiring one quotient bit per cycle; the block takes no new request until the current
// one has finished. the statistics live in a single table memory with one row per
// source, read and written back once per in-range request; a valid bit per row makes
// an untouched row read as zero, so reset is immediate and needs no clearing pass.
// a stalled receiver holds the result in the output register; the next request is
// still accepted and waits in its final state until that result has been taken.
// reset (rst_n low, asynchronous) empties the table and drops any pending result.
`default_nettype none

module per_source_latency_statistics_core #(
    parameter int NUM_SOURCES = psls_pkg::NUM_SOURCES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    psls_req_if.sink  req,
    psls_rsp_if.source rsp
);

    localparam int DW    = psls_pkg::DATA_W;
    localparam int SW    = psls_pkg::SRC_W;
    localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

    psls_pkg::state_t         state_reg;
    psls_pkg::state_t         state_next;
    psls_pkg::req_item_t      item_reg;
    logic                     in_range_reg;
    logic                     row_vld_reg;
    logic [NUM_SOURCES-1:0]   entry_vld_reg;
    psls_pkg::entry_t         rd_data_reg;
    psls_pkg::entry_t         entry_reg;
    psls_pkg::entry_t         entry_next;
    logic [DW-1:0]            mean_reg;
    logic                     rsp_vld_reg;
    psls_pkg::rsp_item_t      rsp_item_reg;

    psls_pkg::entry_t         stats_mem [NUM_SOURCES];

    logic                     accept;
    logic                     in_range;
    logic [SW+IDX_W-1:0]      rd_src_ext;
    logic [SW+IDX_W-1:0]      wr_src_ext;
    logic [IDX_W-1:0]         rd_idx;
    logic [IDX_W-1:0]         wr_idx;
    logic                     mem_we;
    logic                     div_start;
    logic                     rsp_load;
    psls_pkg::entry_t         cur;
    logic [psls_pkg::TOTAL_W:0] total_sum;
    psls_pkg::div_sts_t       div_sts;
    logic [DW-1:0]            div_quotient;

    assign accept     = req.valid && req.ready;
    assign in_range   = (32'(req.item.source) < 32'(NUM_SOURCES));
    assign rd_src_ext = {{IDX_W{1'b0}}, req.item.source};
    assign wr_src_ext = {{IDX_W{1'b0}}, item_reg.source};
    assign rd_idx     = rd_src_ext[IDX_W-1:0];
    assign wr_idx     = wr_src_ext[IDX_W-1:0];

    // table memory, registered read at acceptance, write back in the update step
    always_ff @(posedge clk)
    begin
        if (mem_we)
            stats_mem[wr_idx] <= entry_next;
        if (accept && in_range)
            rd_data_reg <= stats_mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_vld_reg <= '0;
        else if (mem_we)
            entry_vld_reg[wr_idx] <= 1'b1;
    end

    // update of the addressed row
    assign cur       = row_vld_reg ? rd_data_reg : '0;
    assign total_sum = {1'b0, cur.total} + (psls_pkg::TOTAL_W + 1)'(item_reg.delay_us);

    always_comb
    begin
        entry_next = cur;
        unique case (psls_pkg::action_t'(item_reg.action))
            psls_pkg::ACT_PRODUCED:
            begin
                entry_next.made = (cur.made == '1) ? cur.made : cur.made + DW'(1);
            end
            psls_pkg::ACT_CONSUMED:
            begin
                entry_next.eaten = (cur.eaten == '1) ? cur.eaten : cur.eaten + DW'(1);
                entry_next.has   = 1'b1;
                if (!cur.has)
                begin
                    entry_next.min   = item_reg.delay_us;
                    entry_next.max   = item_reg.delay_us;
                    entry_next.total = psls_pkg::TOTAL_W'(item_reg.delay_us);
                end
                else
                begin
                    if (item_reg.delay_us < cur.min)
                        entry_next.min = item_reg.delay_us;
                    if (item_reg.delay_us > cur.max)
                        entry_next.max = item_reg.delay_us;
                    entry_next.total = total_sum[psls_pkg::TOTAL_W] ? '1
                                     : total_sum[psls_pkg::TOTAL_W-1:0];
                end
            end
            psls_pkg::ACT_READ,
            psls_pkg::ACT_SPARE:
            begin
                entry_next = cur;
            end
            default:
            begin
                entry_next = cur;
            end
        endcase
    end

    psls_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (entry_next.total),
        .divisor  (entry_next.eaten),
        .sts      (div_sts),
        .quotient (div_quotient)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= psls_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        mem_we     = 1'b0;
        div_start  = 1'b0;
        rsp_load   = 1'b0;
        unique case (state_reg)
            psls_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                    state_next = psls_pkg::ST_UPDATE;
            end
            psls_pkg::ST_UPDATE:
            begin
                mem_we = in_range_reg;
                if (in_range_reg && entry_next.has && (entry_next.eaten != '0))
                begin
                    div_start  = 1'b1;
                    state_next = psls_pkg::ST_DIVIDE;
                end
                else
                    state_next = psls_pkg::ST_FINISH;
            end
            psls_pkg::ST_DIVIDE:
            begin
                if (div_sts.done)
                    state_next = psls_pkg::ST_FINISH;
            end
            psls_pkg::ST_FINISH:
            begin
                if (!rsp_vld_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = psls_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psls_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg     <= req.item;
            in_range_reg <= in_range;
            row_vld_reg  <= in_range && entry_vld_reg[rd_idx];
        end
        if (state_reg == psls_pkg::ST_UPDATE)
        begin
            entry_reg <= in_range_reg ? entry_next : '0;
            mean_reg  <= '0;
        end
        else if (state_reg == psls_pkg::ST_DIVIDE && div_sts.done)
            mean_reg <= div_quotient;
    end

    // output register, holds a result while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_vld_reg <= 1'b0;
        else if (rsp_load)
            rsp_vld_reg <= 1'b1;
        else if (rsp.ready)
            rsp_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_item_reg.source_echo    <= item_reg.source;
            rsp_item_reg.made_count     <= entry_reg.made;
            rsp_item_reg.eaten_count    <= entry_reg.eaten;
            rsp_item_reg.has_samples    <= entry_reg.has;
            rsp_item_reg.shortest_delay <= entry_reg.min;
            rsp_item_reg.longest_delay  <= entry_reg.max;
            rsp_item_reg.mean_delay     <= mean_reg;
            rsp_item_reg.count_mismatch <= (entry_reg.made != entry_reg.eaten);
        end
    end

    assign rsp.valid = rsp_vld_reg;
    assign rsp.item  = rsp_item_reg;

    // divider activity belongs to the divide step only
    a_div_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        (div_sts.busy || div_sts.done) |-> (state_reg == psls_pkg::ST_DIVIDE))
        else $error("divider active outside the divide step");

    // an out-of-range source must never touch the table
    a_no_stray_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> in_range_reg)
        else $error("table written for an out-of-range source");

    // a finished request waits while the previous result is still stalled
    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == psls_pkg::ST_FINISH && rsp_vld_reg && !rsp.ready)
        |=> (state_reg == psls_pkg::ST_FINISH))
        else $error("result overwritten while stalled");

    // a recorded sample always comes with a non-zero consumed count
    a_samples_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_vld_reg && rsp_item_reg.has_samples) |-> (rsp_item_reg.eaten_count != '0))
        else $error("samples reported with a zero consumed count");

endmodule

`default_nettype wire

@@ design/psls_divider.sv @@
// iterative restoring divider, 64-bit total by 32-bit count, quotient saturated to 32 bits
// depends on psls_pkg
`default_nettype none

module psls_divider (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [psls_pkg::TOTAL_W-1:0]        dividend,
    input  wire logic [psls_pkg::DATA_W-1:0]         divisor,
    output psls_pkg::div_sts_t                       sts,
    output logic      [psls_pkg::DATA_W-1:0]         quotient
);

    localparam int DW    = psls_pkg::DATA_W;
    localparam int CNT_W = $clog2(DW);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    dvd_reg;
    logic [DW-1:0]    dsr_reg;
    logic [DW-1:0]    quo_reg;

    logic [DW:0]      rem_shift;
    logic [DW:0]      rem_diff;
    logic             rem_ge;
    logic             overflow;

    // upper half at or above the divisor means the quotient cannot fit 32 bits
    assign overflow  = (dividend[psls_pkg::TOTAL_W-1:DW] >= divisor);

    assign rem_shift = {rem_reg, dvd_reg[DW-1]};
    assign rem_ge    = (rem_shift >= {1'b0, dsr_reg});
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= !overflow;
                done_reg <= overflow;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[psls_pkg::TOTAL_W-1:DW];
            dvd_reg <= dividend[DW-1:0];
            dsr_reg <= divisor;
            quo_reg <= overflow ? '1 : '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_ge ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
            dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
            quo_reg <= {quo_reg[DW-2:0], rem_ge};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

@@ bench/per_source_latency_statistics_core_tb.sv @@
// testbench for per_source_latency_statistics_core: directed table, then random requests
// depends on psls_pkg and the psls_req_if / psls_rsp_if channel interfaces
`default_nettype none

module per_source_latency_statistics_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SRC    = psls_pkg::NUM_SOURCES_DEF;
    localparam int DATA_W     = psls_pkg::DATA_W;
    localparam int TOTAL_W    = psls_pkg::TOTAL_W;
    localparam int SRC_W      = psls_pkg::SRC_W;
    localparam int RAND_ITEMS = 1480;
    localparam int TAIL_WAIT  = 40;
    localparam int DRAIN_MAX  = 20000;

    typedef struct packed {
        psls_pkg::req_item_t stim;
        logic                typed;
        psls_pkg::rsp_item_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    psls_req_if req();
    psls_rsp_if rsp();

    per_source_latency_statistics_core #(
        .NUM_SOURCES(NUM_SRC)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    always #2ns clk = ~clk;

    // own copy of the statistics table
    logic [DATA_W-1:0]  made_tab  [NUM_SRC];
    logic [DATA_W-1:0]  eaten_tab [NUM_SRC];
    logic               has_tab   [NUM_SRC];
    logic [DATA_W-1:0]  min_tab   [NUM_SRC];
    logic [DATA_W-1:0]  max_tab   [NUM_SRC];
    logic [TOTAL_W-1:0] total_tab [NUM_SRC];

    psls_pkg::rsp_item_t expected_stats[$];

    int errors         = 0;
    int results_seen   = 0;
    int act_seen[4]    = '{0, 0, 0, 0};
    int rx_mode        = 0;
    int rx_hold_cycles = 0;

    function automatic void clear_stats();
        for (int i = 0; i < NUM_SRC; i++)
        begin
            made_tab[i]  = '0;
            eaten_tab[i] = '0;
            has_tab[i]   = 1'b0;
            min_tab[i]   = '0;
            max_tab[i]   = '0;
            total_tab[i] = '0;
        end
    endfunction

    // applies one request to the table and returns the entry as reported
    function automatic psls_pkg::rsp_item_t update_stats(input psls_pkg::req_item_t it);
        psls_pkg::rsp_item_t r;
        int                  s;
        logic [TOTAL_W:0]    sum;
        logic [TOTAL_W-1:0]  quo;
        r = '0;
        r.source_echo = it.source;
        s = int'(it.source);
        if (s >= NUM_SRC)
            return r;
        if (it.action == psls_pkg::ACT_PRODUCED)
        begin
            if (made_tab[s] != '1)
                made_tab[s] = made_tab[s] + 1'b1;
        end
        else if (it.action == psls_pkg::ACT_CONSUMED)
        begin
            if (eaten_tab[s] != '1)
                eaten_tab[s] = eaten_tab[s] + 1'b1;
            if (!has_tab[s])
            begin
                has_tab[s]   = 1'b1;
                min_tab[s]   = it.delay_us;
                max_tab[s]   = it.delay_us;
                total_tab[s] = {32'd0, it.delay_us};
            end
            else
            begin
                if (it.delay_us < min_tab[s])
                    min_tab[s] = it.delay_us;
                if (it.delay_us > max_tab[s])
                    max_tab[s] = it.delay_us;
                sum = {1'b0, total_tab[s]} + {33'd0, it.delay_us};
                total_tab[s] = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            end
        end
        r.made_count  = made_tab[s];
        r.eaten_count = eaten_tab[s];
        r.has_samples = has_tab[s];
        if (has_tab[s])
        begin
            r.shortest_delay = min_tab[s];
            r.longest_delay  = max_tab[s];
            quo = (eaten_tab[s] != '0) ? total_tab[s] / {32'd0, eaten_tab[s]} : '0;
            r.mean_delay = (quo > 64'h0000_0000_FFFF_FFFF) ? '1 : quo[DATA_W-1:0];
        end
        r.count_mismatch = (made_tab[s] != eaten_tab[s]);
        return r;
    endfunction

    function automatic psls_pkg::req_item_t mk_req(input psls_pkg::action_t a,
                                                   input logic [SRC_W-1:0] s,
                                                   input logic [DATA_W-1:0] d);
        psls_pkg::req_item_t it;
        it.action   = a;
        it.source   = s;
        it.delay_us = d;
        return it;
    endfunction

    function automatic psls_pkg::rsp_item_t mk_rsp(input logic [SRC_W-1:0] s,
                                                   input logic [31:0] made,
                                                   input logic [31:0] eaten, input logic has,
                                                   input logic [31:0] mn, input logic [31:0] mx,
                                                   input logic [31:0] mean, input logic mis);
        psls_pkg::rsp_item_t r;
        r.source_echo    = s;
        r.made_count     = made;
        r.eaten_count    = eaten;
        r.has_samples    = has;
        r.shortest_delay = mn;
        r.longest_delay  = mx;
        r.mean_delay     = mean;
        r.count_mismatch = mis;
        return r;
    endfunction

    // mode 0 mixed, 1 no idling, 2 heavy idling
    function automatic int pick_gap(input int mode);
        int unsigned r;
        r = $urandom_range(99);
        if (mode == 1)
            return 0;
        if (mode == 2)
        begin
            if (r < 30)
                return 0;
            if (r < 80)
                return $urandom_range(6, 1);
            return $urandom_range(40, 10);
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic psls_pkg::req_item_t random_request();
        psls_pkg::req_item_t it;
        int unsigned         pick;
        pick = $urandom_range(99);
        if (pick < 40)
            it.action = psls_pkg::ACT_PRODUCED;
        else if (pick < 80)
            it.action = psls_pkg::ACT_CONSUMED;
        else if (pick < 92)
            it.action = psls_pkg::ACT_READ;
        else
            it.action = psls_pkg::ACT_SPARE;
        // a few hot sources so entries build up long histories
        if ($urandom_range(99) < 75)
            it.source = SRC_W'($urandom_range(3));
        else
            it.source = SRC_W'($urandom_range(NUM_SRC - 1));
        pick = $urandom_range(99);
        if (pick < 10)
            it.delay_us = '0;
        else if (pick < 20)
            it.delay_us = '1;
        else if (pick < 60)
            it.delay_us = $urandom_range(1000);
        else if (pick < 80)
            it.delay_us = $urandom_range(100000);
        else
            it.delay_us = $urandom;
        return it;
    endfunction

    task automatic cmp_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= 40)
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_result(input psls_pkg::rsp_item_t got);
        psls_pkg::rsp_item_t want;
        results_seen++;
        if (expected_stats.size() == 0)
        begin
            errors++;
            $display("%0t: result for source %0d with nothing expected, expected none actual %0h",
                     $time, got.source_echo, got);
            return;
        end
        want = expected_stats.pop_front();
        cmp_field("source_echo", want.source_echo, got.source_echo);
        cmp_field("made_count", want.made_count, got.made_count);
        cmp_field("eaten_count", want.eaten_count, got.eaten_count);
        cmp_field("has_samples", want.has_samples, got.has_samples);
        cmp_field("shortest_delay", want.shortest_delay, got.shortest_delay);
        cmp_field("longest_delay", want.longest_delay, got.longest_delay);
        cmp_field("mean_delay", want.mean_delay, got.mean_delay);
        cmp_field("count_mismatch", want.count_mismatch, got.count_mismatch);
    endtask

    // offer one request, hold it until taken, then idle for a random gap that may be zero
    task automatic offer(input psls_pkg::req_item_t it, input logic typed,
                         input psls_pkg::rsp_item_t want, input int mode);
        psls_pkg::rsp_item_t pred;
        int                  gap;
        req.valid <= 1'b1;
        req.item  <= it;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pred = update_stats(it);
        expected_stats.push_back(typed ? want : pred);
        act_seen[it.action]++;
        gap = pick_gap(mode);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_all_results(input int limit);
        int waited;
        waited = 0;
        while (expected_stats.size() != 0 && waited < limit)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    // result side: checks at the edge, then decides ready for the next cycle
    initial
    begin
        int stall;
        stall = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                rsp.ready <= 1'b0;
            else
            begin
                if (rsp.valid && rsp.ready)
                    check_result(rsp.item);
                if (rx_hold_cycles > 0)
                begin
                    rx_hold_cycles--;
                    rsp.ready <= 1'b0;
                end
                else if (stall > 0)
                begin
                    stall--;
                    rsp.ready <= 1'b0;
                end
                else
                begin
                    rsp.ready <= 1'b1;
                    stall = pick_gap(rx_mode);
                end
            end
        end
    end

    initial
    begin
        #4ms;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        dir_row_t rows[$];
        int       mode;
        rst_n     <= 1'b0;
        req.valid <= 1'b0;
        req.item  <= '0;
        clear_stats();

        // fresh table, read and spare, first samples at delay extremes
        rows.push_back({mk_req(psls_pkg::ACT_READ, 4'd0, 32'd0), 1'b1,
                        mk_rsp(4'd0, 0, 0, 1'b0, 0, 0, 0, 1'b0)});
        rows.push_back({mk_req(psls_pkg::ACT_SPARE, 4'd15, 32'hFFFF_FFFF), 1'b1,
                        mk_rsp(4'd15, 0, 0, 1'b0, 0, 0, 0, 1'b0)});
        rows.push_back({mk_req(psls_pkg::ACT_PRODUCED, 4'd1, 32'd0), 1'b1,
                        mk_rsp(4'd1, 1, 0, 1'b0, 0, 0, 0, 1'b1)});
        rows.push_back({mk_req(psls_pkg::ACT_CONSUMED, 4'd1, 32'd0), 1'b1,
                        mk_rsp(4'd1, 1, 1, 1'b1, 0, 0, 0, 1'b0)});
        rows.push_back({mk_req(psls_pkg::ACT_CONSUMED, 4'd1, 32'hFFFF_FFFF), 1'b1,
                        mk_rsp(4'd1, 1, 2, 1'b1, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1)});
        rows.push_back({mk_req(psls_pkg::ACT_CONSUMED, 4'd2, 32'hFFFF_FFFF), 1'b1,
                        mk_rsp(4'd2, 0, 1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 1'b1)});
        rows.push_back({mk_req(psls_pkg::ACT_CONSUMED, 4'd2, 32'hFFFF_FFFF), 1'b1,
                        mk_rsp(4'd2, 0, 2, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 1'b1)});
        rows.push_back({mk_req(psls_pkg::ACT_READ, 4'd2, 32'h1234_5678), 1'b0,
                        psls_pkg::rsp_item_t'('0)});
        rows.push_back({mk_req(psls_pkg::ACT_PRODUCED, 4'd15, 32'hFFFF_FFFF), 1'b0,
                        psls_pkg::rsp_item_t'('0)});
        rows.push_back({mk_req(psls_pkg::ACT_CONSUMED, 4'd15, 32'h5A5A_5A5A), 1'b0,
                        psls_pkg::rsp_item_t'('0)});
        rows.push_back({mk_req(psls_pkg::ACT_CONSUMED, 4'd15, 32'hA5A5_A5A5), 1'b0,
                        psls_pkg::rsp_item_t'('0)});
        rows.push_back({mk_req(psls_pkg::ACT_CONSUMED, 4'd15, 32'd1), 1'b0,
                        psls_pkg::rsp_item_t'('0)});
        rows.push_back({mk_req(psls_pkg::ACT_SPARE, 4'd15, 32'd0), 1'b0,
                        psls_pkg::rsp_item_t'('0)});
        rows.push_back({mk_req(psls_pkg::ACT_PRODUCED, 4'd8, 32'd77), 1'b0,
                        psls_pkg::rsp_item_t'('0)});
        rows.push_back({mk_req(psls_pkg::ACT_PRODUCED, 4'd8, 32'd0), 1'b0,
                        psls_pkg::rsp_item_t'('0)});
        rows.push_back({mk_req(psls_pkg::ACT_CONSUMED, 4'd8, 32'd1000), 1'b0,
                        psls_pkg::rsp_item_t'('0)});
        rows.push_back({mk_req(psls_pkg::ACT_CONSUMED, 4'd8, 32'd3000), 1'b0,
                        psls_pkg::rsp_item_t'('0)});
        rows.push_back({mk_req(psls_pkg::ACT_READ, 4'd8, 32'hFFFF_FFFF), 1'b0,
                        psls_pkg::rsp_item_t'('0)});
        rows.push_back({mk_req(psls_pkg::ACT_PRODUCED, 4'd7, 32'd5), 1'b0,
                        psls_pkg::rsp_item_t'('0)});
        rows.push_back({mk_req(psls_pkg::ACT_CONSUMED, 4'd14, 32'h1234_5678), 1'b0,
                        psls_pkg::rsp_item_t'('0)});
        rows.push_back({mk_req(psls_pkg::ACT_READ, 4'd1, 32'd0), 1'b0,
                        psls_pkg::rsp_item_t'('0)});
        rows.push_back({mk_req(psls_pkg::ACT_SPARE, 4'd2, 32'd9), 1'b0,
                        psls_pkg::rsp_item_t'('0)});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            offer(rows[i].stim, rows[i].typed, rows[i].want, 0);

        req.valid <= 1'b0;
        wait_all_results(DRAIN_MAX);

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            mode = (n / 150) % 3;
            rx_mode = mode;
            // long receiver hold while requests keep coming, so the block backs up
            if (n == 160)
                rx_hold_cycles = 300;
            if (n == 750)
            begin
                req.valid <= 1'b0;
                wait_all_results(DRAIN_MAX);
                @(posedge clk);
            end
            offer(random_request(), 1'b0, psls_pkg::rsp_item_t'('0), mode);
        end

        req.valid <= 1'b0;
        rx_mode = 1;
        wait_all_results(DRAIN_MAX);
        repeat (TAIL_WAIT) @(posedge clk);
        if (expected_stats.size() != 0)
        begin
            errors += expected_stats.size();
            $display("%0t: %0d results never arrived, expected 0 outstanding actual %0d",
                     $time, expected_stats.size(), expected_stats.size());
        end

        $display("requests sent: %0d produce, %0d consume, %0d read, %0d spare action",
                 act_seen[psls_pkg::ACT_PRODUCED], act_seen[psls_pkg::ACT_CONSUMED],
                 act_seen[psls_pkg::ACT_READ], act_seen[psls_pkg::ACT_SPARE]);
        $display("results compared: %0d, mismatches: %0d", results_seen, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
